// File: design/sle_pkg.sv
// Package for the scancode line editor: command word type, shared constants,
// and the set-1 to ASCII lookup tables. No dependencies.
package sle_pkg;

    localparam int MAP_SIZE    = 58;
    localparam int HW_LIMIT    = 63;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

    localparam logic [6:0] CH_NEWLINE   = 7'h0A;
    localparam logic [6:0] CH_BACKSPACE = 7'h08;

    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic [6:0] MAX_LEN_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_BKSP  = 2'd1,
        CMD_ENTER = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] ch;
    } cmd_t;

    localparam logic [6:0] PLAIN_ROM [0:MAP_SIZE-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h20,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
        7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
        7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
        7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D,
        7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [6:0] SHIFTED_ROM [0:MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h20,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
        7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
        7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
        7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D,
        7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

endpackage

// File: design/sle_front.sv
// Front end of the line editor: takes scancode words, tracks shift and maps
// make codes to edit commands. Depends on sle_pkg.
module sle_front
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] scancode,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);

    logic       shift_reg;
    logic       shift_next;
    logic       accept;
    logic       is_cmd;
    logic [6:0] ch;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && cmd_ready;

    always_comb
    begin
        shift_next = shift_reg;
        is_cmd     = 1'b0;
        ch         = '0;
        cmd.kind   = CMD_CHAR;
        if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE)
        begin
            shift_next = 1'b1;
        end
        else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK)
        begin
            shift_next = 1'b0;
        end
        else if (scancode != 8'd0 && !scancode[7] && scancode < 8'(MAP_SIZE))
        begin
            ch     = shift_reg ? SHIFTED_ROM[scancode[5:0]] : PLAIN_ROM[scancode[5:0]];
            is_cmd = (ch != 7'd0);
            if (ch == CH_NEWLINE)
            begin
                cmd.kind = CMD_ENTER;
            end
            else if (ch == CH_BACKSPACE)
            begin
                cmd.kind = CMD_BKSP;
            end
        end
        cmd.ch    = ch;
        cmd_valid = in_valid && is_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else if (accept)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

// File: design/sle_queue.sv
// Short command queue between front and back of the line editor.
// Depends on sle_pkg.
module sle_queue
    import sle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/sle_back.sv
// Back end of the line editor: line store, cursor, echo and line delivery
// through an output register. Depends on sle_pkg.
module sle_back
    import sle_pkg::*;
#(
    parameter int LINE_CAP = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [6:0] max_len,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       is_echo,
    output logic [5:0] line_length,
    output logic       last
);

    localparam int STORE_DEPTH = (LINE_CAP < 64) ? LINE_CAP : 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CAP_LIM     = (LINE_CAP - 1 < HW_LIMIT) ? LINE_CAP - 1 : HW_LIMIT;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  fin_len_reg, fin_len_next;
    logic [6:0]  store [0:STORE_DEPTH-1];
    logic [6:0]  rd_data_reg;
    logic        mem_we;

    logic        out_valid_reg;
    logic [6:0]  out_char_reg;
    logic        out_echo_reg;
    logic [5:0]  out_len_reg;
    logic        out_last_reg;

    logic        load;
    logic [6:0]  load_char;
    logic        load_echo;
    logic [5:0]  load_len;
    logic        load_last;
    logic        out_free;
    logic [6:0]  lim_raw;
    logic [5:0]  limit;

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;

    always_comb
    begin
        lim_raw = (max_len == 7'd0) ? 7'd0 : max_len - 7'd1;
        limit   = (lim_raw > 7'(CAP_LIM)) ? 6'(CAP_LIM) : lim_raw[5:0];
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        fin_len_next = fin_len_reg;
        mem_we       = 1'b0;
        load         = 1'b0;
        load_char    = cmd.ch;
        load_echo    = 1'b1;
        load_len     = pos_reg;
        load_last    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    case (cmd.kind)
                        CMD_ENTER:
                        begin
                            load      = 1'b1;
                            load_char = CH_NEWLINE;
                            load_len  = pos_reg;
                            load_last = (pos_reg == 6'd0);
                            idx_next  = '0;
                            pos_next  = '0;
                            fin_len_next = pos_reg;
                            if (pos_reg != 6'd0)
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        CMD_BKSP:
                        begin
                            if (pos_reg != 6'd0)
                            begin
                                load      = 1'b1;
                                load_char = CH_BACKSPACE;
                                pos_next  = pos_reg - 6'd1;
                                load_len  = pos_reg - 6'd1;
                            end
                        end
                        default:
                        begin
                            if (pos_reg < limit)
                            begin
                                mem_we   = 1'b1;
                                load     = 1'b1;
                                pos_next = pos_reg + 6'd1;
                                load_len = pos_reg + 6'd1;
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                load_char = rd_data_reg;
                load_echo = 1'b0;
                load_len  = fin_len_reg;
                load_last = ({1'b0, idx_reg} + 7'd1 == {1'b0, fin_len_reg});
                if (out_free)
                begin
                    load     = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[pos_reg[ADDR_W-1:0]] <= cmd.ch;
        end
        rd_data_reg <= store[idx_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= load_char;
            out_echo_reg <= load_echo;
            out_len_reg  <= load_len;
            out_last_reg <= load_last;
        end
        fin_len_reg <= fin_len_next;
        idx_reg     <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign is_echo     = out_echo_reg;
    assign line_length = out_len_reg;
    assign last        = out_last_reg;

endmodule

// File: design/scancode_line_editor.sv
// Top level of the scancode line editor: front end, command queue, back end
// and the configuration register port. Depends on sle_pkg and its submodules.
//
// Scancode words are taken one per cycle while the two-entry command queue has
// room; shift, break and unmapped codes leave no trace in the queue. The back
// end does one command per cycle while idle with its output free; a character
// or backspace echoes one word unless the line is full or empty, and Enter on
// a line of n characters gives n+1 words, read one a cycle from the line store
// while the output is free. Results wait in an output register, so input flows
// while the sink stalls until the queue fills. max_len sits at byte address 0.
module scancode_line_editor
    import sle_pkg::*;
#(
    parameter int LINE_CAP = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scancode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] out_char, [12:7] line_length, [15:13] zero
    output logic        m_tuser,   // [0] is_echo
    output logic        m_tlast
);

    logic [6:0] max_len_reg;
    logic       f_valid;
    logic       f_ready;
    cmd_t       f_cmd;
    logic       q_valid;
    logic       q_ready;
    cmd_t       q_cmd;
    logic [6:0] out_char;
    logic [5:0] line_length;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {25'd0, max_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN)
        begin
            max_len_reg <= pwdata[6:0];
        end
    end

    sle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .scancode  (s_tdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    sle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    sle_back #(
        .LINE_CAP (LINE_CAP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_len     (max_len_reg),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_char    (out_char),
        .is_echo     (m_tuser),
        .line_length (line_length),
        .last        (m_tlast)
    );

    assign m_tdata = {3'd0, line_length, out_char};

endmodule

// File: design/sle_checker.sv
// Port-level checks for the scancode line editor, bound to the top level.
// Depends on scancode_line_editor's port list only.
module sle_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_line_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[12:7] != 6'd0)
        else $error("line word with zero length");

    a_echo_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && !m_tlast |-> m_tdata[6:0] == 7'h0A)
        else $error("non-final echo that is not a newline");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:13] == 3'd0)
        else $error("output word pad bits not zero");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
